FILE: rtl/zbst_pkg.sv
// Shared types and codes for the zoned bell schedule timer.
`default_nettype none

package zbst_pkg;

    // Command codes carried in the command field.
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_WR_SCHED = 2'd1;
    localparam logic [1:0] CMD_WR_HOL   = 2'd2;
    localparam logic [1:0] CMD_RESYNC   = 2'd3;

    // Weekend day codes.
    localparam logic [2:0] WDAY_SUNDAY   = 3'd0;
    localparam logic [2:0] WDAY_SATURDAY = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] now_hhmm;
        logic [2:0]  week_day;
        logic [4:0]  month_day;
        logic [3:0]  month_number;
        logic [5:0]  entry_index;
        logic [11:0] entry_time;
        logic [1:0]  entry_zone;
        logic [7:0]  entry_duration;
        logic [4:0]  holiday_day_in;
        logic [3:0]  holiday_month_in;
    } in_item_t;

    typedef struct packed {
        logic        bell_on;
        logic [5:0]  next_slot;
        logic [11:0] next_time;
        logic        off_day;
    } out_item_t;

    typedef struct packed {
        logic [11:0] ring_time;
        logic [1:0]  zone;
        logic [7:0]  length;
    } sched_entry_t;

    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
    } hol_entry_t;

endpackage

`default_nettype wire

FILE: rtl/zoned_bell_schedule_timer.sv
// Top level of the zoned bell schedule timer: tables, sequencer and result register.
`default_nettype none

// Channel  | Ports                          | Direction | Moves
// ---------+--------------------------------+-----------+---------------------------------
// input    | s_valid, s_ready, s_data       | in        | one command transaction
// result   | m_valid, m_ready, m_data       | out       | one status transaction per input
// config   | cfg_valid, cfg_ready, cfg_data | in        | circuit_zone register write
//
// One command occupies the block from acceptance until its result is loaded.
// A write scans the holiday table, then reads the awaited entry and loads the result. A
// resync searches the schedule table before the holiday scan, and a tick reads the awaited
// entry and decides on the ring after the holiday scan; when a ring ends, the next entry is
// searched. Each table has a single read port, which the sequencer walks one entry per cycle.
// Reset is synchronous and active low; the tables read as cleared through per-entry
// valid bits, so no clearing pass is needed. A stalled result holds the block in its
// last step until the result register frees up; the config port is always ready.

module zoned_bell_schedule_timer #(
    parameter int SLOTS         = 64,
    parameter int HOLIDAY_SLOTS = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  zbst_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output zbst_pkg::out_item_t  m_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [1:0]            cfg_data
);
    import zbst_pkg::*;

    // Index widths for each table and for the shared scan counter, which must
    // reach the table depth itself to mark the final compare cycle.
    localparam int SW   = $clog2(SLOTS);
    localparam int HW   = (HOLIDAY_SLOTS > 1) ? $clog2(HOLIDAY_SLOTS) : 1;
    localparam int MAXN = (SLOTS > HOLIDAY_SLOTS) ? SLOTS : HOLIDAY_SLOTS;
    localparam int CW   = $clog2(MAXN + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a command
    localparam logic [2:0] ST_SSCAN = 3'd1;  // schedule search (resync or advance)
    localparam logic [2:0] ST_HSCAN = 3'd2;  // holiday table scan
    localparam logic [2:0] ST_TREAD = 3'd3;  // read the awaited entry for a tick
    localparam logic [2:0] ST_TDEC  = 3'd4;  // tick decision
    localparam logic [2:0] ST_FREAD = 3'd5;  // read the awaited entry for the result
    localparam logic [2:0] ST_FOUT  = 3'd6;  // load the result register

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    in_item_t      item_reg, item_next;
    logic [1:0]    zone_cfg_reg;
    logic [SW-1:0] cur_reg, cur_next;
    logic [7:0]    rc_reg, rc_next;
    logic          ring_reg, ring_next;
    logic          off_reg, off_next;
    logic          found_reg, found_next;
    logic [SW-1:0] fidx_reg, fidx_next;
    logic          adv_reg, adv_next;
    out_item_t     out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    // Schedule table: one write port (at acceptance) and one registered read port.
    sched_entry_t  sched_mem_reg [SLOTS];
    logic [SLOTS-1:0] sched_vld_reg;
    sched_entry_t  sched_rd_reg;
    logic          sched_rdv_reg;
    logic          sched_wr_en;
    logic [SW-1:0] sched_wa;
    logic          sched_rd_en;
    logic [SW-1:0] sched_ra;
    sched_entry_t  sched_q;

    // Holiday table, same arrangement.
    hol_entry_t    hol_mem_reg [HOLIDAY_SLOTS];
    logic [HOLIDAY_SLOTS-1:0] hol_vld_reg;
    hol_entry_t    hol_rd_reg;
    logic          hol_rdv_reg;
    logic          hol_wr_en;
    logic [HW-1:0] hol_wa;
    logic          hol_rd_en;
    logic [HW-1:0] hol_ra;
    hol_entry_t    hol_q;

    logic          s_acc;
    logic [SW-1:0] scan_k;
    logic          scan_match;
    logic          scan_hit;
    logic [SW-1:0] scan_pick;
    logic          hol_hit;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // Table writes happen in the acceptance cycle, straight from the input.
    assign sched_wr_en = s_acc && (s_data.command == CMD_WR_SCHED) &&
                         (32'(s_data.entry_index) < SLOTS);
    assign sched_wa    = SW'(s_data.entry_index);
    assign hol_wr_en   = s_acc && (s_data.command == CMD_WR_HOL) &&
                         (32'(s_data.entry_index) < HOLIDAY_SLOTS);
    assign hol_wa      = HW'(s_data.entry_index);

    // An entry never written reads as the cleared value.
    assign sched_q = sched_rdv_reg ? sched_rd_reg : '0;
    assign hol_q   = hol_rdv_reg ? hol_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (sched_wr_en) begin
            sched_mem_reg[sched_wa] <= '{ring_time: s_data.entry_time,
                                         zone:      s_data.entry_zone,
                                         length:    s_data.entry_duration};
        end
        if (sched_rd_en) begin
            sched_rd_reg  <= sched_mem_reg[sched_ra];
            sched_rdv_reg <= sched_vld_reg[sched_ra];
        end
        if (hol_wr_en) begin
            hol_mem_reg[hol_wa] <= '{day: s_data.holiday_day_in,
                                     month: s_data.holiday_month_in};
        end
        if (hol_rd_en) begin
            hol_rd_reg  <= hol_mem_reg[hol_ra];
            hol_rdv_reg <= hol_vld_reg[hol_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_vld_reg <= '0;
            hol_vld_reg   <= '0;
        end else begin
            if (sched_wr_en) begin
                sched_vld_reg[sched_wa] <= 1'b1;
            end
            if (hol_wr_en) begin
                hol_vld_reg[hol_wa] <= 1'b1;
            end
        end
    end

    // The scan counter runs one ahead of the compare: at count n the read of
    // entry n is issued while entry n-1 is compared.
    assign scan_k = SW'(cnt_reg - CW'(1));

    // Shared compare unit for both schedule searches. Resync looks for the first
    // own-zone entry at or after now; advance for the first own-zone entry past
    // the awaited slot.
    always_comb begin
        scan_match = (sched_q.zone == zone_cfg_reg) &&
                     (adv_reg ? (scan_k > cur_reg)
                              : (sched_q.ring_time >= item_reg.now_hhmm));
    end
    assign scan_hit  = (cnt_reg != '0) && scan_match;
    assign scan_pick = found_reg ? fidx_reg : scan_k;

    // A holiday entry counts only when both of its fields are in use.
    assign hol_hit = (cnt_reg != '0) && (hol_q.day != '0) && (hol_q.month != '0) &&
                     (hol_q.day == item_reg.month_day) &&
                     (hol_q.month == item_reg.month_number);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        item_next    = item_reg;
        cur_next     = cur_reg;
        rc_next      = rc_reg;
        ring_next    = ring_reg;
        off_next     = off_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        adv_next     = adv_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        sched_rd_en  = 1'b0;
        sched_ra     = SW'(cnt_reg);
        hol_rd_en    = 1'b0;
        hol_ra       = HW'(cnt_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    item_next  = s_data;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    off_next   = (s_data.week_day == WDAY_SUNDAY) ||
                                 (s_data.week_day == WDAY_SATURDAY);
                    if (s_data.command == CMD_RESYNC) begin
                        adv_next   = 1'b0;
                        state_next = ST_SSCAN;
                    end else begin
                        state_next = ST_HSCAN;
                    end
                end
            end
            ST_SSCAN: begin
                if (cnt_reg < CW'(SLOTS)) begin
                    sched_rd_en = 1'b1;
                end
                if (scan_hit && !found_reg) begin
                    found_next = 1'b1;
                    fidx_next  = scan_k;
                end
                if (cnt_reg == CW'(SLOTS)) begin
                    cur_next = (found_reg || scan_hit) ? scan_pick : '0;
                    cnt_next = '0;
                    if (adv_reg) begin
                        state_next = ST_FREAD;
                    end else begin
                        // Resync drops any ring in progress.
                        rc_next    = '0;
                        ring_next  = 1'b0;
                        state_next = ST_HSCAN;
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_HSCAN: begin
                if (cnt_reg < CW'(HOLIDAY_SLOTS)) begin
                    hol_rd_en = 1'b1;
                end
                if (hol_hit) begin
                    off_next = 1'b1;
                end
                if (cnt_reg == CW'(HOLIDAY_SLOTS)) begin
                    state_next = (item_reg.command == CMD_TICK) ? ST_TREAD : ST_FREAD;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_TREAD: begin
                sched_rd_en = 1'b1;
                sched_ra    = cur_reg;
                state_next  = ST_TDEC;
            end
            ST_TDEC: begin
                state_next = ST_FREAD;
                if (!ring_reg) begin
                    if (!off_reg && (sched_q.ring_time == item_reg.now_hhmm) &&
                        (sched_q.zone == zone_cfg_reg)) begin
                        ring_next = 1'b1;
                    end
                end else begin
                    rc_next = rc_reg + 8'd1;
                    if (rc_reg == sched_q.length) begin
                        rc_next    = '0;
                        ring_next  = 1'b0;
                        adv_next   = 1'b1;
                        found_next = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_SSCAN;
                    end
                end
            end
            ST_FREAD: begin
                sched_rd_en = 1'b1;
                sched_ra    = cur_reg;
                state_next  = ST_FOUT;
            end
            ST_FOUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = '{bell_on:   ring_reg,
                                 next_slot: 6'(cur_reg),
                                 next_time: sched_q.ring_time,
                                 off_day:   off_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            zone_cfg_reg <= '0;
            cur_reg      <= '0;
            rc_reg       <= '0;
            ring_reg     <= 1'b0;
            off_reg      <= 1'b0;
            found_reg    <= 1'b0;
            fidx_reg     <= '0;
            adv_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_reg     <= cur_next;
            rc_reg      <= rc_next;
            ring_reg    <= ring_next;
            off_reg     <= off_next;
            found_reg   <= found_next;
            fidx_reg    <= fidx_next;
            adv_reg     <= adv_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                zone_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

FILE: rtl/zbst_checker.sv
// Port-level checker for the zoned bell schedule timer and its bind.
`default_nettype none

module zbst_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input zbst_pkg::in_item_t  s_data,
    input wire                 m_valid,
    input wire                 m_ready,
    input zbst_pkg::out_item_t m_data,
    input wire                 cfg_valid,
    input wire                 cfg_ready,
    input wire [1:0]           cfg_data
);
    import zbst_pkg::*;

    // A stalled result transaction keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // The block works on one command at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a command is in progress");

    // Reset leaves no result pending and the input side open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("bad state after reset");

    // The config register never stalls.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind zoned_bell_schedule_timer zbst_checker u_zbst_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire
